@@ sv/face_vertex_dedup_triangulator_assert.svh @@
// Assertion macros shared by the checkers of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FACE_VERTEX_DEDUP_TRIANGULATOR_ASSERT_SVH
`define FACE_VERTEX_DEDUP_TRIANGULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FVDT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fvdt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FVDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fvdt assertion failed");

`endif

@@ sv/fvdt_pkg.sv @@
package fvdt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int INDEX_BITS  = 16;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W   = 3 * INDEX_BITS;
  localparam int UID_W   = 8;
  localparam int TOTAL_W = 9;
  localparam int COUNT_W = 4;
  localparam int POS_W   = 4;
  localparam int NUM_W   = POS_W + 1;

  localparam logic [COUNT_W-1:0] TRI_CORNERS  = 4'd3;
  localparam logic [COUNT_W-1:0] QUAD_CORNERS = 4'd4;
  localparam logic [NUM_W-1:0]   THIRD_CORNER  = 5'd3;
  localparam logic [NUM_W-1:0]   FOURTH_CORNER = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT
  } fvdt_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } fvdt_cmd_t;

  typedef struct packed {
    logic active;
    logic hit;
    logic miss;
    logic emit;
    logic out_busy;
  } fvdt_sts_t;

  function automatic logic [UID_W-1:0] to_uid(input logic [CNT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[UID_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(input logic [CNT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

@@ sv/fvdt_if.sv @@
interface fvdt_in_if;
  import fvdt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] pos_index;
  logic [INDEX_BITS-1:0] tex_index;
  logic [INDEX_BITS-1:0] norm_index;
  logic [COUNT_W-1:0]    corner_count;

  modport source (output valid, output pos_index, output tex_index, output norm_index,
                  output corner_count, input ready);
  modport sink (input valid, input pos_index, input tex_index, input norm_index,
                input corner_count, output ready);
endinterface

interface fvdt_out_if;
  import fvdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [UID_W-1:0]   tri_first;
  logic [UID_W-1:0]   tri_second;
  logic [UID_W-1:0]   tri_third;
  logic [TOTAL_W-1:0] unique_total;
  logic               table_overflow;

  modport source (output valid, output tri_first, output tri_second, output tri_third,
                  output unique_total, output table_overflow, input ready);
  modport sink (input valid, input tri_first, input tri_second, input tri_third,
                input unique_total, input table_overflow, output ready);
endinterface

@@ sv/fvdt_ctrl.sv @@
module fvdt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fvdt_pkg::fvdt_sts_t sts,
  output fvdt_pkg::fvdt_cmd_t cmd
);
  import fvdt_pkg::*;

  fvdt_state_t state_r;
  fvdt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.active ? ST_SCAN : ST_COMMIT;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.miss) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!(sts.emit && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/fvdt_datapath.sv @@
module fvdt_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fvdt_pkg::fvdt_cmd_t               cmd,
  output fvdt_pkg::fvdt_sts_t               sts,
  input  logic [fvdt_pkg::INDEX_BITS-1:0]   pos_index,
  input  logic [fvdt_pkg::INDEX_BITS-1:0]   tex_index,
  input  logic [fvdt_pkg::INDEX_BITS-1:0]   norm_index,
  input  logic [fvdt_pkg::COUNT_W-1:0]      corner_count,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [fvdt_pkg::UID_W-1:0]        tri_first,
  output logic [fvdt_pkg::UID_W-1:0]        tri_second,
  output logic [fvdt_pkg::UID_W-1:0]        tri_third,
  output logic [fvdt_pkg::TOTAL_W-1:0]      unique_total,
  output logic                              table_overflow
);
  import fvdt_pkg::*;

  logic [KEY_W-1:0]   mem [TABLE_DEPTH];

  logic [KEY_W-1:0]   key_r;
  logic [COUNT_W-1:0] count_r;
  logic [POS_W-1:0]   pos_r;
  logic [UID_W-1:0]   saved_r [3];
  logic               ovf_r;
  logic [CNT_W-1:0]   entry_r;
  logic [CNT_W-1:0]   scan_r;
  logic               rd_vld_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [KEY_W-1:0]   rd_data_r;
  logic [UID_W-1:0]   uid_r;

  logic               out_valid_r;
  logic [UID_W-1:0]   tri_first_r;
  logic [UID_W-1:0]   tri_second_r;
  logic [UID_W-1:0]   tri_third_r;
  logic [TOTAL_W-1:0] unique_total_r;
  logic               table_overflow_r;

  logic [NUM_W-1:0]   number;
  logic [1:0]         slot;
  logic               active;
  logic               hit;
  logic               miss;
  logic               full;
  logic               issue;
  logic               insert;
  logic               emit;

  always_comb begin
    number = {1'b0, pos_r} + NUM_W'(1);
    slot   = number[1:0] - 2'd1;
    active = (count_r inside {TRI_CORNERS, QUAD_CORNERS}) &&
             (number <= {1'b0, count_r});
    hit    = rd_vld_r && (rd_data_r == key_r);
    miss   = !rd_vld_r && (scan_r >= entry_r);
    full   = (entry_r == CNT_W'(TABLE_DEPTH));
    issue  = cmd.scan && (scan_r < entry_r);
    insert = cmd.scan && miss && !full;
    emit   = active && (number inside {THIRD_CORNER, FOURTH_CORNER});
  end

  assign sts.active   = active;
  assign sts.hit      = hit;
  assign sts.miss     = miss;
  assign sts.emit     = emit;
  assign sts.out_busy = out_valid_r && !out_ready;

  // Table of unique triples: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (insert) begin
      mem[entry_r[ADDR_W-1:0]] <= key_r;
    end
    if (issue) begin
      rd_data_r <= mem[scan_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= {pos_index, tex_index, norm_index};
      count_r <= corner_count;
    end
    if (issue) begin
      rd_idx_r <= scan_r;
    end
    if (cmd.scan && (hit || miss)) begin
      if (hit) begin
        uid_r <= to_uid(rd_idx_r);
      end else if (full) begin
        uid_r <= '0;
      end else begin
        uid_r <= to_uid(entry_r);
      end
    end
    if (cmd.commit && emit) begin
      tri_first_r      <= saved_r[0];
      tri_second_r     <= (number == THIRD_CORNER) ? saved_r[1] : saved_r[2];
      tri_third_r      <= uid_r;
      unique_total_r   <= to_total(entry_r);
      table_overflow_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      entry_r     <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      saved_r[0]  <= '0;
      saved_r[1]  <= '0;
      saved_r[2]  <= '0;
    end else begin
      if (cmd.accept) begin
        scan_r   <= '0;
        rd_vld_r <= 1'b0;
        if (pos_r == '0) begin
          ovf_r <= 1'b0;
        end
      end
      if (cmd.scan) begin
        rd_vld_r <= issue;
        if (issue) begin
          scan_r <= scan_r + CNT_W'(1);
        end
        if (insert) begin
          entry_r <= entry_r + CNT_W'(1);
        end
        if (miss && full) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        pos_r <= (number >= {1'b0, count_r}) ? '0 : number[POS_W-1:0];
        if (active && (number <= THIRD_CORNER)) begin
          saved_r[slot] <= uid_r;
        end
      end
      if (cmd.commit && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign tri_first      = tri_first_r;
  assign tri_second     = tri_second_r;
  assign tri_third      = tri_third_r;
  assign unique_total   = unique_total_r;
  assign table_overflow = table_overflow_r;

endmodule

@@ sv/face_vertex_dedup_triangulator.sv @@
// Takes one face corner per item and turns faces of three or four corners into triangles
// of unique vertex indices. Each corner triple of a triangle or quad is searched in a table
// of unique triples by a linear scan of the table memory, one entry per cycle through its
// single registered read port; a miss appends the triple. Corners of faces with other
// corner counts skip the scan and give no result. A corner of a triangle or quad scans the
// stored entries until a hit, or all of them on a miss. One item is processed at a time;
// a finished triangle sits in an output register, and the next corner is accepted while it
// waits. A miss on a full table yields index 0 and sets table_overflow for the rest of
// that face.
module face_vertex_dedup_triangulator (
  input logic       clk,
  input logic       rst_n,
  fvdt_in_if.sink   in_item,
  fvdt_out_if.source out_item
);
  import fvdt_pkg::*;

  fvdt_cmd_t cmd;
  fvdt_sts_t sts;

  fvdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fvdt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .pos_index      (in_item.pos_index),
    .tex_index      (in_item.tex_index),
    .norm_index     (in_item.norm_index),
    .corner_count   (in_item.corner_count),
    .out_ready      (out_item.ready),
    .out_valid      (out_item.valid),
    .tri_first      (out_item.tri_first),
    .tri_second     (out_item.tri_second),
    .tri_third      (out_item.tri_third),
    .unique_total   (out_item.unique_total),
    .table_overflow (out_item.table_overflow)
  );

endmodule

@@ sv/fvdt_checker.sv @@
`include "face_vertex_dedup_triangulator_assert.svh"

module fvdt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fvdt_pkg::UID_W-1:0]     tri_first,
  input logic [fvdt_pkg::UID_W-1:0]     tri_second,
  input logic [fvdt_pkg::UID_W-1:0]     tri_third,
  input logic [fvdt_pkg::TOTAL_W-1:0]   unique_total,
  input logic                           table_overflow
);
  import fvdt_pkg::*;

  // A stalled triangle is held unchanged.
  `FVDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tri_first) && $stable(tri_second) && $stable(tri_third) && $stable(unique_total))

  // Corners are processed one at a time.
  `FVDT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // Without an overflow every corner refers to a stored triple.
  `FVDT_ASSERT_IMPL(a_index_bound, out_valid && !table_overflow, (TOTAL_W'(tri_first) < unique_total) && (TOTAL_W'(tri_second) < unique_total) && (TOTAL_W'(tri_third) < unique_total))

  // An overflow is only reported once the table is full.
  `FVDT_ASSERT_IMPL(a_full_on_ovf, out_valid && table_overflow, unique_total == TOTAL_W'(TABLE_DEPTH))

endmodule

bind face_vertex_dedup_triangulator fvdt_checker u_fvdt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .tri_first      (out_item.tri_first),
  .tri_second     (out_item.tri_second),
  .tri_third      (out_item.tri_third),
  .unique_total   (out_item.unique_total),
  .table_overflow (out_item.table_overflow)
);
